// ----- hw/rtl/clst_pkg.sv -----
// ----------------------------------------------------------------------------
// clst_pkg
// Shared types and codes of the compacting list store: command codes,
// result status codes, read data values and the controller state type.
// ----------------------------------------------------------------------------
package clst_pkg;

  // command codes carried by an input beat
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // read data for an out-of-range read
  localparam logic signed [31:0] READ_MISS = -32'sd1;

  // read data for commands that return no word
  localparam logic signed [31:0] READ_NONE = 32'sd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT
  } clst_state_t;

endpackage

// ----- hw/rtl/compacting_list_store.sv -----
// ----------------------------------------------------------------------------
// compacting_list_store
// Bounded ordered list of signed 32-bit words with append, read at index and
// remove at index; remove compacts the later entries down one place.
// ----------------------------------------------------------------------------
// usage
//   input beat: in_command, in_index, in_value are taken at a rising edge
//   where start is high and busy is low.
//   result beat: out_read_data, out_status, out_entry_count are valid for
//   exactly one cycle while out_strobe is high; the receiver cannot stall,
//   so every result must be captured in that cycle.
// command flow
//   append, out-of-range commands, unused command code and removal of the
//   last entry: result in the cycle after the start beat, busy stays low, so
//   one of these can be issued every cycle.
//   read in range: busy while in ST_READ; the result is registered from the
//   registered memory read data after ST_READ.
//   remove in range: busy is high in ST_SHIFT, where the entries behind the
//   index move down one at a time, and the result comes after the last one
//   has moved; the single port pair of the entry memory moves one word per
//   cycle.
// reset
//   rst_n (synchronous) empties the list; stored words are not cleared.
// ----------------------------------------------------------------------------
module compacting_list_store
  import clst_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_command,
  input  logic [3:0]          in_index,
  input  logic signed [31:0]  in_value,
  output logic                out_strobe,
  output logic signed [31:0]  out_read_data,
  output logic [1:0]          out_status,
  output logic [4:0]          out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 4) ? CW : 4;
  localparam int OW = (CW > 5) ? CW : 5;

  clst_state_t state_r, state_nxt;

  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic               strobe_r, strobe_nxt;
  logic signed [31:0] rdata_out_r, rdata_out_nxt;
  logic [1:0]         status_r, status_nxt;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic signed [31:0] mem_wdata, mem_rdata;

  logic               accept;
  logic [XW-1:0]      idx_x, cnt_x;
  logic               idx_ok, is_full, rm_last, shift_more;
  logic [CW-1:0]      ptr_plus2;
  logic [OW-1:0]      cnt_o;

  // beat decode
  assign accept     = start && !busy;
  assign idx_x      = XW'(in_index);
  assign cnt_x      = XW'(count_r);
  assign idx_ok     = idx_x < cnt_x;
  assign is_full    = count_r == CW'(DEPTH);
  assign rm_last    = (idx_x + XW'(1)) == cnt_x;
  assign ptr_plus2  = CW'(ptr_r) + CW'(2);
  assign shift_more = ptr_plus2 < count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && idx_ok) begin
          if (in_command == CMD_READ) begin
            state_nxt = ST_READ;
          end else if (in_command == CMD_REMOVE && !rm_last) begin
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      ST_SHIFT: begin
        if (!shift_more) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // memory control and busy
  always_comb begin
    busy      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = in_value;
    mem_re    = 1'b0;
    mem_raddr = idx_x[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_APPEND && !is_full) begin
            mem_we = 1'b1;
          end else if (in_command == CMD_READ && idx_ok) begin
            mem_re = 1'b1;
          end else if (in_command == CMD_REMOVE && idx_ok && !rm_last) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(idx_x + XW'(1));
          end
        end
      end
      ST_READ: begin
        busy = 1'b1;
      end
      ST_SHIFT: begin
        // move one word down; fetch the next one behind it
        busy      = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = mem_rdata;
        mem_re    = shift_more;
        mem_raddr = ptr_plus2[AW-1:0];
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // datapath and result next values
  always_comb begin
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    strobe_nxt    = 1'b0;
    rdata_out_nxt = rdata_out_r;
    status_nxt    = status_r;
    case (state_r)
      ST_IDLE: begin
        ptr_nxt = idx_x[AW-1:0];
        if (accept) begin
          strobe_nxt    = 1'b1;
          rdata_out_nxt = READ_NONE;
          status_nxt    = STAT_OK;
          case (in_command)
            CMD_APPEND: begin
              if (is_full) begin
                status_nxt = STAT_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_READ: begin
              if (idx_ok) begin
                strobe_nxt = 1'b0;
              end else begin
                rdata_out_nxt = READ_MISS;
                status_nxt    = STAT_RANGE;
              end
            end
            CMD_REMOVE: begin
              if (!idx_ok) begin
                status_nxt = STAT_RANGE;
              end else if (rm_last) begin
                count_nxt = count_r - CW'(1);
              end else begin
                strobe_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        strobe_nxt    = 1'b1;
        rdata_out_nxt = mem_rdata;
        status_nxt    = STAT_OK;
      end
      ST_SHIFT: begin
        ptr_nxt = ptr_r + AW'(1);
        if (!shift_more) begin
          strobe_nxt    = 1'b1;
          rdata_out_nxt = READ_NONE;
          status_nxt    = STAT_OK;
          count_nxt     = count_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    rdata_out_r <= rdata_out_nxt;
    status_r    <= status_nxt;
  end

  clst_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result beat
  assign cnt_o           = OW'(count_r);
  assign out_strobe      = strobe_r;
  assign out_read_data   = rdata_out_r;
  assign out_status      = status_r;
  assign out_entry_count = cnt_o[4:0];

  // count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  // an in-range read always returns its beat right after ST_READ
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> out_strobe)
    else $error("read result missing");

  // shift never reads the entry it is overwriting
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && mem_re) |-> mem_raddr != mem_waddr)
    else $error("shift read and write collide");

  // no result while a shift still has words to move
  a_shift_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && shift_more) |=> !out_strobe)
    else $error("early result during shift");

  // count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) ||
         count_r == CW'($past(count_r) + CW'(1)) ||
         count_r == CW'($past(count_r) - CW'(1))))
    else $error("count jumped");

endmodule

// ----- hw/rtl/clst_mem.sv -----
// ----------------------------------------------------------------------------
// clst_mem
// Entry storage: one write port and one read port, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module clst_mem
  import clst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [31:0]   wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic signed [31:0]   rdata
);

  logic signed [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
